// ===== hdl/ahot_pkg.sv =====
// Shared types and constants for the action hit ordinal table.
// Used by ahot_table_mem, ahot_scan_unit and action_hit_ordinal_table.
// No dependencies.
package ahot_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 256;

    localparam int KIND_W    = 2;
    localparam int SUBJECT_W = 64;
    localparam int GEN_W     = 32;
    localparam int EPOCH_W   = 32;
    localparam int ACTION_W  = 64;
    localparam int COUNT_W   = 13;
    localparam int STAMP_W   = 64;
    localparam int ORD_W     = 12;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] ORDINAL_MAX = COUNT_W'(4095);

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SUBJECT_W-1:0] subject;
        logic [GEN_W-1:0]     generation;
        logic [EPOCH_W-1:0]   map_epoch;
        logic [ACTION_W-1:0]  action;
        logic [EPOCH_W-1:0]   action_epoch;
    } t_key;

    typedef struct packed {
        t_key                 key;
        logic [COUNT_W-1:0]   count;
        logic [STAMP_W-1:0]   stamp;
    } t_entry;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic cmp_valid;
    } t_scan_ctl;

    // Result of a completed scan.
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] hit_count;
    } t_scan_stat;

endpackage

// ===== hdl/ahot_table_mem.sv =====
// Table storage: one write port and one registered read port.
// Depends on ahot_pkg for the entry type.
module ahot_table_mem
    import ahot_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ahot_scan_unit.sv =====
// Shared compare unit: checks one table entry per cycle for a key match and
// tracks the entry with the smallest use stamp. Depends on ahot_pkg.
module ahot_scan_unit
    import ahot_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_cmp_idx,
    input  t_key             i_key,
    input  t_entry           i_entry,
    output t_scan_stat       o_stat,
    output logic [IDX_W-1:0] o_hit_idx,
    output logic [IDX_W-1:0] o_min_idx
);

    logic               r_hit;
    logic               r_min_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [COUNT_W-1:0] r_hit_count;
    logic [IDX_W-1:0]   r_min_idx;
    logic [STAMP_W-1:0] r_min_stamp;

    logic key_match;
    logic older;

    assign key_match = (i_entry.key == i_key);
    // Strictly older only, so the lowest index wins among equal stamps.
    assign older     = !r_min_found || (i_entry.stamp < r_min_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_min_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit       <= 1'b0;
            r_min_found <= 1'b0;
        end else if (i_ctl.cmp_valid) begin
            if (key_match) begin
                r_hit <= 1'b1;
            end
            r_min_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_valid && !i_ctl.clear) begin
            if (key_match && !r_hit) begin
                r_hit_idx   <= i_cmp_idx;
                r_hit_count <= i_entry.count;
            end
            if (older) begin
                r_min_idx   <= i_cmp_idx;
                r_min_stamp <= i_entry.stamp;
            end
        end
    end

    assign o_stat.hit       = r_hit;
    assign o_stat.hit_count = r_hit_count;
    assign o_hit_idx        = r_hit_idx;
    assign o_min_idx        = r_min_idx;

endmodule

// ===== hdl/action_hit_ordinal_table.sv =====
// A new transaction is accepted only in idle, after the previous one is through: a scan reads
// each of the live entries once through the single table read port (occupancy, the number of
// live entries, is at most TABLE_ENTRIES), then the update writes the table and the result;
// the update also waits while the previous result is held by i_stall.
// Reset: synchronous, active low; it empties the table through the fill count
// and clears the use counter; no clearing pass is needed.
module action_hit_ordinal_table
    import ahot_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KIND_W-1:0]    i_subject_kind,
    input  logic [SUBJECT_W-1:0] i_subject_id,
    input  logic [GEN_W-1:0]     i_subject_generation,
    input  logic [EPOCH_W-1:0]   i_map_epoch,
    input  logic [ACTION_W-1:0]  i_action_number,
    input  logic [EPOCH_W-1:0]   i_action_epoch,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ORD_W-1:0]     o_hit_ordinal
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_raddr, n_raddr;
    logic               r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [STAMP_W-1:0] r_use, n_use;
    logic               r_o_valid, n_o_valid;
    logic [ORD_W-1:0]   r_o_ord, n_o_ord;
    t_key               r_key, n_key;

    logic               accept;
    logic               out_free;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_idx;
    t_entry             mem_wr_data;
    logic               mem_rd_en;
    t_entry             mem_rd_data;
    t_scan_ctl          scan_ctl;
    t_scan_stat         scan_stat;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   min_idx;
    logic [COUNT_W-1:0] old_count;
    logic [COUNT_W-1:0] new_count;
    logic [STAMP_W-1:0] new_stamp;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    assign scan_ctl.clear     = accept;
    assign scan_ctl.cmp_valid = r_cmp_valid;

    ahot_table_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_idx  (mem_wr_idx),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_idx  (r_raddr[IDX_W-1:0]),
        .o_rd_data (mem_rd_data)
    );

    ahot_scan_unit #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_cmp_idx (r_cmp_idx),
        .i_key     (r_key),
        .i_entry   (mem_rd_data),
        .o_stat    (scan_stat),
        .o_hit_idx (hit_idx),
        .o_min_idx (min_idx)
    );

    // Entries fill from index zero and an evicted slot is refilled at once,
    // so the live entries are always the first r_occ slots.
    always_comb begin
        mem_wr_idx = min_idx;
        old_count  = '0;
        n_occ      = r_occ;
        if (scan_stat.hit) begin
            mem_wr_idx = hit_idx;
            old_count  = scan_stat.hit_count;
        end else if (r_occ < ENTRIES) begin
            mem_wr_idx = r_occ[IDX_W-1:0];
        end
        new_count = (old_count < COUNT_LIMIT) ? old_count + COUNT_W'(1) : old_count;
        new_stamp = r_use + STAMP_W'(1);
    end

    assign mem_wr_data.key   = r_key;
    assign mem_wr_data.count = new_count;
    assign mem_wr_data.stamp = new_stamp;

    always_comb begin
        n_state     = r_state;
        n_raddr     = r_raddr;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_use       = r_use;
        n_o_valid   = r_o_valid && i_stall;
        n_o_ord     = r_o_ord;
        n_key       = r_key;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key.kind         = i_subject_kind;
                    n_key.subject      = i_subject_id;
                    n_key.generation   = i_subject_generation;
                    n_key.map_epoch    = i_map_epoch;
                    n_key.action       = i_action_number;
                    n_key.action_epoch = i_action_epoch;
                    n_raddr            = '0;
                    n_cmp_valid        = 1'b0;
                    n_state            = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_raddr < r_occ) begin
                    mem_rd_en   = 1'b1;
                    n_cmp_idx   = r_raddr[IDX_W-1:0];
                    n_cmp_valid = 1'b1;
                    n_raddr     = r_raddr + CNT_W'(1);
                end else begin
                    n_cmp_valid = 1'b0;
                    if (!r_cmp_valid) begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    mem_wr_en = 1'b1;
                    n_use     = new_stamp;
                    n_o_valid = 1'b1;
                    n_o_ord   = (new_count <= ORDINAL_MAX) ? new_count[ORD_W-1:0] : '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_raddr     <= '0;
            r_cmp_valid <= 1'b0;
            r_occ       <= '0;
            r_use       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_raddr     <= n_raddr;
            r_cmp_valid <= n_cmp_valid;
            if (mem_wr_en) begin
                r_occ <= n_occ + CNT_W'(!scan_stat.hit && (r_occ < ENTRIES));
            end
            r_use       <= n_use;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_o_ord   <= n_o_ord;
        r_key     <= n_key;
    end

    assign o_valid       = r_o_valid;
    assign o_hit_ordinal = r_o_ord;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= ENTRIES)
        else $error("table occupancy exceeds the table size");

    a_occ_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_occ >= $past(r_occ))
        else $error("table occupancy decreased outside reset");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && scan_stat.hit) |-> (CNT_W'(hit_idx) < r_occ))
        else $error("matched entry lies beyond the live entries");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr_en) |=> (o_valid && r_state == S_IDLE))
        else $error("table update did not produce a result");
`endif

endmodule
